// ===== hw/rtl/scmmdw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scmmdw_pkg;

	// raw word index before folding into the memory depth (one spare bit for a full-size modulus)
	localparam int RAW_IDX_W = 19;

	// index fold for depths that are not a power of two: estimate, subtract, correct
	localparam int FOLD_W     = 2;
	localparam int FOLD_STEPS = 3;

	localparam logic [FOLD_W-1:0] FOLD_EST = 2'd2;
	localparam logic [FOLD_W-1:0] FOLD_SUB = 2'd1;
	localparam logic [FOLD_W-1:0] FOLD_FIX = 2'd0;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BANK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRIO = 2'd2;

	localparam logic [1:0] PRIO_NORMAL = 2'd0;
	localparam logic [1:0] PRIO_UNDER  = 2'd1;
	localparam logic [1:0] PRIO_OVER   = 2'd2;
	localparam logic [1:0] PRIO_NONE   = 2'd3;

	localparam logic [2:0] TGT_PRAM = 3'd0;
	localparam logic [2:0] TGT_WRAM = 3'd1;
	localparam logic [2:0] TGT_NONE = 3'd2;
	localparam logic [2:0] TGT_BRAM = 3'd3;
	localparam logic [2:0] TGT_PCM  = 3'd4;
	localparam logic [2:0] TGT_IO   = 3'd5;

	localparam logic [19:0] PRAM_END  = 20'h07ffff;
	localparam logic [19:0] WRAM2_END = 20'h0bffff;
	localparam logic [19:0] WRAM1_END = 20'h0dffff;
	localparam logic [19:0] PCM_BASE  = 20'h0f0000;
	localparam logic [19:0] IO_BASE   = 20'h0f8000;

	typedef struct packed {
		logic        opcode;
		logic        upper_enable;
		logic        lower_enable;
		logic [23:0] bus_address;
		logic [15:0] bus_data;
	} access_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic [2:0]  target;
		logic [19:0] forward_address;
		logic [15:0] forward_data;
		logic        forward_upper;
		logic        forward_lower;
	} result_t;

	typedef struct packed {
		logic              capture;
		logic              step;
		logic [FOLD_W-1:0] fold;
		logic              rd_en;
		logic              wb;
	} cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/scmmdw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scmmdw_ctrl #(
	parameter int STEPS = 0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	output logic                done,
	output scmmdw_pkg::cmd_t    cmd
);

	localparam int CNT_W = (STEPS < 2) ? 1 : $clog2(STEPS);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_REDUCE = 2'd1;
	localparam logic [1:0] S_READ   = 2'd2;
	localparam logic [1:0] S_WB     = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_WB);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (STEPS == 0) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_REDUCE;
						end
						cnt_q <= CNT_W'(STEPS - 1);
					end
				end
				S_REDUCE: begin
					// one fold step per cycle, the count names the step
					if (cnt_q == '0) begin
						state_q <= S_READ;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_READ: begin
					state_q <= S_WB;
				end
				S_WB: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	always_comb begin
		cmd.capture = (state_q == S_IDLE) && start;
		cmd.step    = (state_q == S_REDUCE);
		cmd.fold    = scmmdw_pkg::FOLD_W'(cnt_q);
		cmd.rd_en   = (state_q == S_READ);
		cmd.wb      = (state_q == S_WB);
	end

endmodule

`default_nettype wire

// ===== hw/rtl/scmmdw_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scmmdw_dp #(
	parameter int PROGRAM_WORDS  = 262144,
	parameter int WORD_RAM_WORDS = 131072
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  scmmdw_pkg::cmd_t                         cmd,
	input  scmmdw_pkg::access_t                      access,
	input  wire                                      cfg_we,
	input  wire [scmmdw_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire [scmmdw_pkg::CFG_DATA_W-1:0]         cfg_data,
	output scmmdw_pkg::result_t                      result
);

	localparam int PIDX_W = $clog2(PROGRAM_WORDS);
	localparam int WIDX_W = $clog2(WORD_RAM_WORDS);
	localparam int RW     = scmmdw_pkg::RAW_IDX_W;

	// reciprocal of the smallest allowed depth, 2^19 / 1024, still fits
	localparam int RECIP_W = RW - 9;
	localparam int PROD_W  = RW + RECIP_W;

	localparam logic [RECIP_W-1:0] PROG_RECIP = RECIP_W'((1 << RW) / PROGRAM_WORDS);
	localparam logic [RECIP_W-1:0] WRAM_RECIP = RECIP_W'((1 << RW) / WORD_RAM_WORDS);

	localparam logic [1:0] K_NONE  = 2'd0;
	localparam logic [1:0] K_PLAIN = 2'd1;
	localparam logic [1:0] K_DOT   = 2'd2;

	function automatic logic [3:0] nib_store(input logic [1:0] prio, input logic [3:0] cur,
			input logic [3:0] nw);
		logic [3:0] r;
		unique case (prio)
			scmmdw_pkg::PRIO_NORMAL: r = nw;
			scmmdw_pkg::PRIO_UNDER:  r = (cur == 4'd0) ? nw : cur;
			scmmdw_pkg::PRIO_OVER:   r = (nw != 4'd0) ? nw : cur;
			scmmdw_pkg::PRIO_NONE:   r = cur;
		endcase
		return r;
	endfunction

	// configuration
	logic       mode_q;
	logic       bank_q;
	logic [1:0] prio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			bank_q <= 1'b0;
			prio_q <= scmmdw_pkg::PRIO_NORMAL;
		end else if (cfg_we) begin
			if (cfg_index == scmmdw_pkg::REG_MODE) mode_q <= cfg_data[0];
			if (cfg_index == scmmdw_pkg::REG_BANK) bank_q <= cfg_data[0];
			if (cfg_index == scmmdw_pkg::REG_PRIO) prio_q <= cfg_data;
		end
	end

	// address decode of the incoming beat
	logic [19:0]   a;
	logic          inv;
	logic [2:0]    tgt_d;
	logic [1:0]    kind_d;
	logic          sel_prog_d;
	logic [RW-1:0] raw_d;

	assign a   = access.bus_address[19:0];
	assign inv = ~bank_q;

	always_comb begin
		tgt_d      = scmmdw_pkg::TGT_NONE;
		kind_d     = K_NONE;
		sel_prog_d = 1'b0;
		raw_d      = '0;
		priority if (a <= scmmdw_pkg::PRAM_END) begin
			tgt_d      = scmmdw_pkg::TGT_PRAM;
			kind_d     = K_PLAIN;
			sel_prog_d = 1'b1;
			raw_d      = RW'(a[19:1]);
		end else if (a <= scmmdw_pkg::WRAM2_END) begin
			tgt_d = scmmdw_pkg::TGT_WRAM;
			if (!mode_q) begin
				kind_d = K_PLAIN;
				raw_d  = RW'(a[17:1]);
			end else begin
				kind_d = K_DOT;
				raw_d  = RW'({a[17:2], inv});
			end
		end else if (a <= scmmdw_pkg::WRAM1_END) begin
			if (mode_q) begin
				tgt_d  = scmmdw_pkg::TGT_WRAM;
				kind_d = K_PLAIN;
				raw_d  = RW'({a[16:1], inv});
			end
		end else if (a < scmmdw_pkg::PCM_BASE) begin
			if (access.lower_enable) tgt_d = scmmdw_pkg::TGT_BRAM;
		end else if (a < scmmdw_pkg::IO_BASE) begin
			if (access.lower_enable) tgt_d = scmmdw_pkg::TGT_PCM;
		end else begin
			tgt_d = scmmdw_pkg::TGT_IO;
		end
	end

	// held access
	logic [2:0]         tgt_q;
	logic [1:0]         kind_q;
	logic               sel_prog_q;
	logic               dot_low_q;
	logic               wr_q;
	logic               up_q;
	logic               lo_q;
	logic [19:0]        addr_q;
	logic [15:0]        data_q;
	logic [RW-1:0]      idx_q;
	logic [RW-1:0]      mod;
	logic [RECIP_W-1:0] recip;
	logic [RECIP_W-1:0] quot_q;
	logic [PROD_W-1:0]  recip_prod;
	logic [PROD_W-1:0]  fold_prod;

	assign mod        = sel_prog_q ? RW'(PROGRAM_WORDS) : RW'(WORD_RAM_WORDS);
	assign recip      = sel_prog_q ? PROG_RECIP : WRAM_RECIP;
	assign recip_prod = PROD_W'(idx_q) * PROD_W'(recip);
	assign fold_prod  = PROD_W'(quot_q) * PROD_W'(mod);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tgt_q      <= tgt_d;
			kind_q     <= kind_d;
			sel_prog_q <= sel_prog_d;
			dot_low_q  <= a[1];
			wr_q       <= access.opcode;
			up_q       <= access.upper_enable;
			lo_q       <= access.lower_enable;
			addr_q     <= a;
			data_q     <= access.bus_data;
			idx_q      <= raw_d;
		end else if (cmd.step) begin
			// fold the index into the memory depth; the estimate is low by at most one
			unique case (cmd.fold)
				scmmdw_pkg::FOLD_EST: quot_q <= recip_prod[RW +: RECIP_W];
				scmmdw_pkg::FOLD_SUB: idx_q <= idx_q - fold_prod[RW-1:0];
				scmmdw_pkg::FOLD_FIX: if (idx_q >= mod) idx_q <= idx_q - mod;
				default: ;
			endcase
		end
	end

	// memories, read data registered
	logic [15:0] prog_mem [PROGRAM_WORDS];
	logic [15:0] wram_mem [WORD_RAM_WORDS];
	logic [15:0] prog_rd_q;
	logic [15:0] wram_rd_q;
	logic        prog_we;
	logic        wram_we;
	logic [15:0] merged;
	logic [15:0] dot_word;
	logic [15:0] wram_wdata;

	always_ff @(posedge clk) begin
		if (cmd.rd_en) prog_rd_q <= prog_mem[idx_q[PIDX_W-1:0]];
		if (prog_we) prog_mem[idx_q[PIDX_W-1:0]] <= merged;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) wram_rd_q <= wram_mem[idx_q[WIDX_W-1:0]];
		if (wram_we) wram_mem[idx_q[WIDX_W-1:0]] <= wram_wdata;
	end

	// write-back and result
	logic [15:0] old;
	logic [7:0]  byte_old;
	logic [3:0]  hi_new;
	logic [3:0]  lw_new;
	logic [15:0] rd;
	logic        fwd;

	always_comb begin
		old      = sel_prog_q ? prog_rd_q : wram_rd_q;
		merged   = {up_q ? data_q[15:8] : old[15:8], lo_q ? data_q[7:0] : old[7:0]};
		// address bit 1 picks the low byte of the word
		byte_old = dot_low_q ? old[7:0] : old[15:8];
		hi_new   = up_q ? nib_store(prio_q, byte_old[7:4], data_q[11:8]) : byte_old[7:4];
		lw_new   = lo_q ? nib_store(prio_q, byte_old[3:0], data_q[3:0]) : byte_old[3:0];
		dot_word = dot_low_q ? {old[15:8], hi_new, lw_new} : {hi_new, lw_new, old[7:0]};

		prog_we    = cmd.wb && wr_q && (kind_q == K_PLAIN) && sel_prog_q;
		wram_we    = cmd.wb && wr_q && (((kind_q == K_PLAIN) && !sel_prog_q) ||
			(kind_q == K_DOT));
		wram_wdata = (kind_q == K_DOT) ? dot_word : merged;

		if (wr_q) begin
			rd = 16'd0;
		end else begin
			unique case (kind_q)
				K_PLAIN: rd = old;
				K_DOT:   rd = {4'd0, byte_old[7:4], 4'd0, byte_old[3:0]};
				K_NONE:  rd = data_q;
				default: rd = data_q;
			endcase
		end
		fwd = (tgt_q >= scmmdw_pkg::TGT_BRAM);
	end

	scmmdw_pkg::result_t res_q;

	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			res_q.read_data       <= rd;
			res_q.target          <= tgt_q;
			res_q.forward_address <= fwd ? addr_q : 20'd0;
			res_q.forward_data    <= fwd ? data_q : 16'd0;
			res_q.forward_upper   <= fwd & up_q;
			res_q.forward_lower   <= fwd & lo_q;
		end
	end

	assign result = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sub_cpu_memory_map_dot_window_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sub-CPU memory map with the word RAM dot-mapped window. An access is taken on a clock
// edge with start high and busy low, then goes through the read and write-back states;
// its single result is on result with done high for exactly one cycle, and must be
// captured at the edge that ends that cycle. The next access can be taken at that same
// edge, so accesses never overlap. The time is set by the single-port RAM: the word is
// read in the read state, then lanes or nibbles are merged and written back in write-back.
// When either RAM depth is not a power of two, the word index is first folded into the
// depth by a reciprocal multiply, a subtract and a final correction. Program RAM and word
// RAM are not cleared at reset. Configuration writes are taken on any edge with cfg_we
// high; the user must make them only while idle, as the block does not enforce it.

module sub_cpu_memory_map_dot_window_unit #(
	parameter int PROGRAM_WORDS  = 262144,
	parameter int WORD_RAM_WORDS = 131072
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	input  scmmdw_pkg::access_t                   access,
	output logic                                  busy,
	output logic                                  done,
	output scmmdw_pkg::result_t                   result,
	input  wire                                   cfg_we,
	input  wire [scmmdw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [scmmdw_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam bit  BOTH_POW2 = ((PROGRAM_WORDS & (PROGRAM_WORDS - 1)) == 0) &&
		((WORD_RAM_WORDS & (WORD_RAM_WORDS - 1)) == 0);
	localparam int  STEPS = BOTH_POW2 ? 0 : scmmdw_pkg::FOLD_STEPS;

	scmmdw_pkg::cmd_t cmd;

	scmmdw_ctrl #(
		.STEPS(STEPS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	scmmdw_dp #(
		.PROGRAM_WORDS  (PROGRAM_WORDS),
		.WORD_RAM_WORDS (WORD_RAM_WORDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.access    (access),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

`ifndef SYNTH
	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not make the unit busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && !busy))
		else $error("result strobe without a finished access");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_forward_only_when_forwarded: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.target == scmmdw_pkg::TGT_PRAM ||
			result.target == scmmdw_pkg::TGT_WRAM ||
			result.target == scmmdw_pkg::TGT_NONE)) |->
		(result.forward_address == 20'd0 && !result.forward_upper && !result.forward_lower))
		else $error("forward fields set for a local access");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import scmmdw_pkg::*;

	localparam int PROG_DEPTH  = 262144;
	localparam int WRAM_DEPTH  = 131072;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 10;
	localparam int PHASE_BEATS = 175;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef enum logic [2:0] {
		AREA_PROG, AREA_WORD, AREA_DOT, AREA_OFF, AREA_BRAM, AREA_PCM, AREA_IO
	} area_e;

	class memory_map_model;
		bit [15:0] prog_words [PROG_DEPTH];
		bit [1:0]  prog_valid [PROG_DEPTH];
		bit [15:0] wram_words [WRAM_DEPTH];
		bit [1:0]  wram_valid [WRAM_DEPTH];
		logic       mode;
		logic       bank;
		logic [1:0] prio;
		result_t    expected_results [$];
		int         errors;

		function new();
			mode   = 1'b0;
			bank   = 1'b0;
			prio   = PRIO_NORMAL;
			errors = 0;
		endfunction

		function void locate(input access_t acc, output area_e area,
				output int unsigned idx, output bit low_byte);
			logic [19:0] a;
			a        = acc.bus_address[19:0];
			idx      = 0;
			low_byte = 1'b0;
			if (a <= PRAM_END) begin
				area = AREA_PROG;
				idx  = a[18:1];
			end else if (a <= WRAM2_END) begin
				if (!mode) begin
					area = AREA_WORD;
					idx  = a[17:1];
				end else begin
					// dot window: one byte of word ram per bus word
					area     = AREA_DOT;
					idx      = {a[17:2], ~bank};
					low_byte = a[1];
				end
			end else if (a <= WRAM1_END) begin
				if (mode) begin
					area = AREA_WORD;
					idx  = {a[16:1], ~bank};
				end else begin
					area = AREA_OFF;
				end
			end else if (a < PCM_BASE) begin
				area = acc.lower_enable ? AREA_BRAM : AREA_OFF;
			end else if (a < IO_BASE) begin
				area = acc.lower_enable ? AREA_PCM : AREA_OFF;
			end else begin
				area = AREA_IO;
			end
		endfunction

		function logic [3:0] nibble_store(input logic [3:0] cur, input logic [3:0] nw);
			case (prio)
				PRIO_NORMAL: return nw;
				PRIO_UNDER:  return (cur == 4'h0) ? nw : cur;
				PRIO_OVER:   return (nw != 4'h0) ? nw : cur;
				default:     return cur;
			endcase
		endfunction

		// true when the beat would look at ram contents never written
		function bit reads_unwritten(input access_t acc);
			area_e       area;
			int unsigned idx;
			bit          low_byte;
			bit [1:0]    v;
			bit          full;
			locate(acc, area, idx, low_byte);
			full = acc.upper_enable && acc.lower_enable;
			case (area)
				AREA_PROG: v = prog_valid[idx];
				AREA_WORD, AREA_DOT: v = wram_valid[idx];
				default: return 1'b0;
			endcase
			if (area == AREA_DOT)
				return !v[low_byte ? 0 : 1] &&
					!(acc.opcode == OP_WRITE && prio == PRIO_NORMAL && full);
			return (v != 2'b11) && !(acc.opcode == OP_WRITE && full);
		endfunction

		function void note_access(input access_t acc);
			result_t     r;
			area_e       area;
			int unsigned idx;
			bit          low_byte;
			logic [15:0] w;
			logic [1:0]  v;
			logic [3:0]  hi;
			logic [3:0]  lw;
			int          sh;
			locate(acc, area, idx, low_byte);
			r           = '0;
			r.target    = TGT_NONE;
			r.read_data = (acc.opcode == OP_WRITE) ? 16'h0000 : acc.bus_data;
			case (area)
				AREA_PROG, AREA_WORD: begin
					if (area == AREA_PROG) begin
						r.target = TGT_PRAM;
						w        = prog_words[idx];
						v        = prog_valid[idx];
					end else begin
						r.target = TGT_WRAM;
						w        = wram_words[idx];
						v        = wram_valid[idx];
					end
					if (acc.opcode == OP_WRITE) begin
						if (acc.upper_enable) begin
							w[15:8] = acc.bus_data[15:8];
							v[1]    = 1'b1;
						end
						if (acc.lower_enable) begin
							w[7:0] = acc.bus_data[7:0];
							v[0]   = 1'b1;
						end
						if (area == AREA_PROG) begin
							prog_words[idx] = w;
							prog_valid[idx] = v;
						end else begin
							wram_words[idx] = w;
							wram_valid[idx] = v;
						end
					end else begin
						// plain reads give both lanes whatever the enables
						r.read_data = w;
					end
				end
				AREA_DOT: begin
					r.target = TGT_WRAM;
					w        = wram_words[idx];
					sh       = low_byte ? 0 : 8;
					hi       = w[sh+4 +: 4];
					lw       = w[sh +: 4];
					if (acc.opcode == OP_WRITE) begin
						if (acc.upper_enable) hi = nibble_store(hi, acc.bus_data[11:8]);
						if (acc.lower_enable) lw = nibble_store(lw, acc.bus_data[3:0]);
						w[sh +: 8]      = {hi, lw};
						wram_words[idx] = w;
						if (prio == PRIO_NORMAL && acc.upper_enable && acc.lower_enable)
							wram_valid[idx][sh/8] = 1'b1;
					end else begin
						r.read_data = {4'h0, hi, 4'h0, lw};
					end
				end
				AREA_OFF: r.target = TGT_NONE;
				default: begin
					case (area)
						AREA_BRAM: r.target = TGT_BRAM;
						AREA_PCM:  r.target = TGT_PCM;
						default:   r.target = TGT_IO;
					endcase
					r.forward_address = acc.bus_address[19:0];
					r.forward_data    = acc.bus_data;
					r.forward_upper   = acc.upper_enable;
					r.forward_lower   = acc.lower_enable;
				end
			endcase
			expected_results.push_back(r);
		endfunction

		function void check_result(input result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: data %h target %0d", got.read_data, got.target);
				return;
			end
			want = expected_results.pop_front();
			if (got.read_data !== want.read_data || got.target !== want.target ||
					got.forward_address !== want.forward_address ||
					got.forward_data !== want.forward_data ||
					got.forward_upper !== want.forward_upper ||
					got.forward_lower !== want.forward_lower) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %h %0d %h %h %b %b, got %h %0d %h %h %b %b",
						want.read_data, want.target, want.forward_address,
						want.forward_data, want.forward_upper, want.forward_lower,
						got.read_data, got.target, got.forward_address,
						got.forward_data, got.forward_upper, got.forward_lower);
			end
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	access_t               access    = '0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_MODE;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  busy;
	logic                  done;
	result_t               result;

	memory_map_model map_model = new;
	logic [19:0]     write_history [$];
	int unsigned     prog_base [4];
	int unsigned     wram_base [4];
	bit              idle_on = 1'b1;
	int              stall_cycles = 0;

	sub_cpu_memory_map_dot_window_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.access    (access),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) map_model.check_result(result);
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("** sub_cpu_memory_map_dot_window_unit: FAILED **");
			$finish;
		end
	end

	task automatic send_access(input access_t acc);
		if (idle_on && $urandom_range(0, 99) < 33) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 33);
		end
		start  <= 1'b1;
		access <= acc;
		do @(posedge clk); while (busy !== 1'b0);
		map_model.note_access(acc);
	endtask

	task automatic send(input logic op, input logic up, input logic lo,
			input logic [23:0] addr, input logic [15:0] data);
		access_t acc;
		acc.opcode       = op;
		acc.upper_enable = up;
		acc.lower_enable = lo;
		acc.bus_address  = addr;
		acc.bus_data     = data;
		send_access(acc);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (map_model.expected_results.size() != 0 || busy !== 1'b0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic m, input logic b, input logic [1:0] pr);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_MODE;
		cfg_data  <= {1'b0, m};
		@(posedge clk);
		cfg_index <= REG_BANK;
		cfg_data  <= {1'b0, b};
		@(posedge clk);
		cfg_index <= REG_PRIO;
		cfg_data  <= pr;
		@(posedge clk);
		cfg_we <= 1'b0;
		map_model.mode = m;
		map_model.bank = b;
		map_model.prio = pr;
	endtask

	function automatic int unsigned pick_index(input int unsigned bases [4],
			input int unsigned depth);
		if ($urandom_range(0, 7) == 0) return $urandom_range(0, depth - 1);
		return (bases[$urandom_range(0, 3)] + $urandom_range(0, 31)) % depth;
	endfunction

	function automatic access_t random_access();
		access_t     acc;
		int unsigned pick;
		int unsigned wi;
		logic [19:0] a;
		logic [15:0] d;
		pick = $urandom_range(0, 99);
		d    = 16'($urandom);
		// zero nibbles matter for under and over writes
		if ($urandom_range(0, 2) == 0)
			for (int k = 0; k < 4; k++)
				if ($urandom_range(0, 1) == 1) d[k*4 +: 4] = 4'h0;
		if (pick < 30) begin
			wi = pick_index(prog_base, PROG_DEPTH);
			a  = {1'b0, wi[17:0], 1'($urandom)};
		end else if (pick < 48) begin
			wi = pick_index(wram_base, WRAM_DEPTH);
			if (map_model.mode)
				a = {2'b10, wi[16:1], 1'($urandom), 1'($urandom)};
			else
				a = {2'b10, wi[16:0], 1'($urandom)};
		end else if (pick < 62) begin
			wi = pick_index(wram_base, WRAM_DEPTH);
			a  = {3'b110, wi[16:1], 1'($urandom)};
		end else if (pick < 74) begin
			a = {4'he, 16'($urandom)};
		end else if (pick < 86) begin
			a = {5'b11110, 15'($urandom)};
		end else begin
			a = {5'b11111, 15'($urandom)};
		end
		acc.opcode       = 1'($urandom);
		acc.upper_enable = 1'($urandom);
		acc.lower_enable = 1'($urandom);
		acc.bus_address  = {4'($urandom), a};
		acc.bus_data     = d;
		for (int t = 0; t < 4 && map_model.reads_unwritten(acc); t++)
			if (write_history.size() != 0)
				acc.bus_address = {4'($urandom),
					write_history[$urandom_range(0, write_history.size() - 1)]};
		if (map_model.reads_unwritten(acc)) begin
			// fall back to a full program ram write, always safe
			acc.opcode          = OP_WRITE;
			acc.upper_enable    = 1'b1;
			acc.lower_enable    = 1'b1;
			acc.bus_address[19] = 1'b0;
		end
		return acc;
	endfunction

	initial begin
		access_t    acc;
		logic       m;
		logic       b;
		logic [1:0] pr;
		prog_base[0] = 0;
		prog_base[1] = PROG_DEPTH - 32;
		prog_base[2] = $urandom_range(0, PROG_DEPTH - 32);
		prog_base[3] = $urandom_range(0, PROG_DEPTH - 32);
		wram_base[0] = 0;
		wram_base[1] = WRAM_DEPTH - 32;
		wram_base[2] = $urandom_range(0, WRAM_DEPTH - 32);
		wram_base[3] = $urandom_range(0, WRAM_DEPTH - 32);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// linear mode, reset settings
		send(OP_WRITE, 1'b1, 1'b1, 24'h000000, 16'ha55a);
		send(OP_READ,  1'b0, 1'b0, 24'hf00000, 16'h1357);
		send(OP_WRITE, 1'b1, 1'b1, 24'h07fffe, 16'h1234);
		send(OP_WRITE, 1'b1, 1'b0, 24'ha7ffff, 16'hffff);
		send(OP_READ,  1'b1, 1'b1, 24'h07fffe, 16'h0000);
		send(OP_WRITE, 1'b1, 1'b1, 24'h0bfffe, 16'hffff);
		send(OP_WRITE, 1'b1, 1'b1, 24'h080000, 16'h8001);
		send(OP_READ,  1'b0, 1'b1, 24'h5bffff, 16'hffff);
		// inactive window, then forwarded regions with the lower lane off and on
		send(OP_READ,  1'b1, 1'b1, 24'h0c0000, 16'hbeef);
		send(OP_WRITE, 1'b1, 1'b1, 24'h0dfffe, 16'hcafe);
		send(OP_WRITE, 1'b1, 1'b0, 24'h0e0001, 16'h0f0f);
		send(OP_READ,  1'b0, 1'b1, 24'hfeffff, 16'h1111);
		send(OP_WRITE, 1'b1, 1'b1, 24'h0f0000, 16'h2222);
		send(OP_READ,  1'b1, 1'b0, 24'h0f7fff, 16'h3333);
		send(OP_WRITE, 1'b0, 1'b0, 24'h0fffff, 16'hffff);

		set_config(1'b1, 1'b0, PRIO_NORMAL);
		send(OP_WRITE, 1'b1, 1'b1, 24'h0c0000, 16'h0000);
		send(OP_WRITE, 1'b1, 1'b1, 24'h080000, 16'hff0a);
		send(OP_READ,  1'b0, 1'b0, 24'h080002, 16'h0000);
		send(OP_READ,  1'b1, 1'b1, 24'h080001, 16'h0000);
		set_config(1'b1, 1'b0, PRIO_UNDER);
		send(OP_WRITE, 1'b1, 1'b1, 24'h080002, 16'h0c03);
		send(OP_WRITE, 1'b1, 1'b1, 24'h080000, 16'h0505);
		set_config(1'b1, 1'b1, PRIO_OVER);
		send(OP_WRITE, 1'b1, 1'b0, 24'h080000, 16'h0000);
		send(OP_WRITE, 1'b0, 1'b1, 24'h080002, 16'h0007);
		// no-write priority still targets word ram
		set_config(1'b1, 1'b1, PRIO_NONE);
		send(OP_WRITE, 1'b1, 1'b1, 24'h080002, 16'hffff);
		send(OP_READ,  1'b1, 1'b1, 24'h0c0000, 16'h0000);

		for (int p = 0; p < PHASES; p++) begin
			if (p < 4) begin
				m  = 1'b1;
				b  = 1'(p);
				pr = 2'(p);
			end else if (p == 4) begin
				m  = 1'b0;
				b  = 1'b1;
				pr = PRIO_NONE;
			end else begin
				m  = 1'($urandom);
				b  = 1'($urandom);
				pr = 2'($urandom);
			end
			set_config(m, b, pr);
			// one stretch back to back
			idle_on = (p != 2);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				acc = random_access();
				if (acc.opcode == OP_WRITE) begin
					write_history.push_back(acc.bus_address[19:0]);
					if (write_history.size() > 64) void'(write_history.pop_front());
				end
				send_access(acc);
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (map_model.errors == 0 && map_model.expected_results.size() == 0) begin
			$display("** sub_cpu_memory_map_dot_window_unit: PASSED **");
		end else begin
			$display("** sub_cpu_memory_map_dot_window_unit: FAILED **");
		end
		$finish;
	end

endmodule
